/* hdl/swci_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swci_pkg
// Shared constants for the sliding-window choppiness index block.
// ----------------------------------------------------------------------------
package swci_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SMP_W      = 16;
	localparam int CI_W       = 15;
	localparam int CNT_W      = 32;
	// sum of up to MAX_WINDOW-1 absolute steps of 16-bit samples
	localparam int SUM_W      = SMP_W + $clog2(MAX_WINDOW);
	localparam int EXP_W      = $clog2(SUM_W);
	localparam int LOG_W      = EXP_W + 16;
	localparam int LN_W       = $clog2(WIN_W) + 16;
	localparam int DVD_W      = LOG_W + CI_W + 1;

	localparam logic [CI_W-1:0] CI_NEUTRAL = 15'd15821;
	localparam logic [CI_W-1:0] CI_FULL    = 15'd25600;

	localparam logic [WIN_W-1:0] WIN_RESET  = 7'd14;
	localparam logic [WIN_W-1:0] MIN_RESET  = 7'd2;
	localparam logic [CI_W-1:0]  TREND_RESET = 15'd9779;
	localparam logic [CI_W-1:0]  CHOP_RESET  = 15'd15821;

	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_MIN    = 2'd1,
		REG_TREND  = 2'd2,
		REG_CHOP   = 2'd3
	} reg_idx_t;

endpackage
`default_nettype wire

/* hdl/swci_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swci_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module swci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/sliding_window_choppiness_index_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_choppiness_index_top
// Ring window of bias samples; sum of steps, range, log2 ratio, index events.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | bias_sample
//  out     | out_valid / out_ready   | choppiness, events, counts
//  cfg     | cfg_we                  | cfg_addr, cfg_data
//
//  an item with too few samples goes from idle straight to the finish step
//  otherwise: window walk, three logs on the shared squaring unit, one
//  multiply and a restoring divide, with early exits to the finish step
//  in_ready is high only in idle; a word in the output register does not block
//  the next input, only the finish step waits for a free output register
//  asynchronous reset clears control, counters and config to defaults
// ----------------------------------------------------------------------------
module sliding_window_choppiness_index_top import swci_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [SMP_W-1:0] bias_sample,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CI_W-1:0]        choppiness,
	output logic                   trend_event,
	output logic                   chop_event,
	output logic [CNT_W-1:0]       trend_count,
	output logic [CNT_W-1:0]       chop_count,
	output logic [CNT_W-1:0]       sample_count,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_addr,
	input  wire logic [CI_W-1:0]   cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_WALK  = 7'b0000010,
		ST_LNORM = 7'b0000100,
		ST_LSQ   = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		SEL_SUM = 2'd0,
		SEL_RNG = 2'd1,
		SEL_N   = 2'd2
	} log_sel_t;

	state_t            st_q;
	log_sel_t          sel_q;
	logic [WIN_W-1:0]  win_q, min_q;
	logic [CI_W-1:0]   trend_thr_q, chop_thr_q;
	logic [ADDR_W-1:0] wp_q;
	logic [WIN_W-1:0]  fill_q, n_q, iss_q, rcv_q;
	logic [ADDR_W-1:0] raddr_q;
	logic              rvalid_q, comp_q;
	logic              was_trend_q, was_chop_q;
	logic [CNT_W-1:0]  tcnt_q, ccnt_q, scnt_q;
	logic signed [SMP_W-1:0] prev_q, lo_q, hi_q;
	logic [SUM_W-1:0]  sum_q;
	logic [EXP_W-1:0]  e_q;
	logic [30:0]       m_q;
	logic [15:0]       frac_q;
	logic [3:0]        k_q;
	logic [LOG_W-1:0]  lsum_q, lrng_q;
	logic [LN_W-1:0]   ln_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [LN_W-1:0]   rem_q;
	logic [5:0]        dc_q;
	logic [CI_W-1:0]   ci_q;
	logic              ovalid_q;

	// effective window
	logic [WIN_W-1:0]  w;
	always_comb begin
		priority if (win_q < WIN_W'(2)) begin
			w = WIN_W'(2);
		end else if (win_q > WIN_W'(MAX_WINDOW)) begin
			w = WIN_W'(MAX_WINDOW);
		end else begin
			w = win_q;
		end
	end

	// accept path
	logic              acc;
	logic [ADDR_W-1:0] wp_use;
	logic [WIN_W-1:0]  wp_inc, fill_new;
	logic [ADDR_W-1:0] wp_new;
	logic [WIN_W:0]    start_sum;
	logic [ADDR_W-1:0] start;

	assign in_ready = (st_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		wp_use    = (WIN_W'(wp_q) >= w) ? '0 : wp_q;
		wp_inc    = WIN_W'(wp_use) + WIN_W'(1);
		wp_new    = (wp_inc == w) ? '0 : wp_inc[ADDR_W-1:0];
		fill_new  = (fill_q < w) ? fill_q + WIN_W'(1) : fill_q;
		start_sum = (WIN_W+1)'(wp_new) + (WIN_W+1)'(w) - (WIN_W+1)'(fill_new);
		start     = (start_sum >= (WIN_W+1)'(w)) ?
			ADDR_W'(start_sum - (WIN_W+1)'(w)) : ADDR_W'(start_sum);
	end

	logic [SMP_W-1:0] rdata;
	logic [WIN_W-1:0] raddr_inc;
	assign raddr_inc = WIN_W'(raddr_q) + WIN_W'(1);

	swci_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WINDOW)) u_store (
		.clk   (clk),
		.we    (acc),
		.waddr (wp_use),
		.wdata (bias_sample),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	// walk arithmetic
	logic signed [SMP_W-1:0] cur;
	logic signed [SMP_W:0]   dif;
	logic [SMP_W-1:0]        adif;
	logic signed [SMP_W:0]   rng_full;
	logic [SMP_W-1:0]        rng;

	always_comb begin
		cur      = signed'(rdata);
		dif      = {cur[SMP_W-1], cur} - {prev_q[SMP_W-1], prev_q};
		adif     = dif[SMP_W] ? SMP_W'(-dif) : SMP_W'(dif);
		rng_full = {hi_q[SMP_W-1], hi_q} - {lo_q[SMP_W-1], lo_q};
		rng      = SMP_W'(rng_full);
	end

	// shared log2 unit: normalize, then one squaring per fraction bit
	function automatic logic [EXP_W-1:0] msb_idx(input logic [SUM_W-1:0] x);
		logic [EXP_W-1:0] r;
		r = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (x[i]) begin
				r = EXP_W'(i);
			end
		end
		return r;
	endfunction

	logic [SUM_W-1:0] lx;
	logic [EXP_W-1:0] le;
	logic [30:0]      lm;
	logic [61:0]      prod;
	logic [31:0]      sq;
	logic [15:0]      frac_new;
	logic [LOG_W-1:0] lres;

	always_comb begin
		unique case (sel_q)
			SEL_SUM: lx = sum_q;
			SEL_RNG: lx = SUM_W'(rng);
			SEL_N:   lx = SUM_W'(n_q);
			default: lx = sum_q;
		endcase
		le       = msb_idx(lx);
		lm       = 31'({{(31 - SUM_W){1'b0}}, lx} << (EXP_W'(30) - le));
		prod     = 62'(m_q) * 62'(m_q);
		sq       = prod[61:30];
		frac_new = {frac_q[14:0], sq[31]};
		lres     = {e_q, frac_new};
	end

	// multiply and divide
	logic signed [LOG_W:0] d;
	logic [LN_W:0]         rem_n;
	logic                  qbit;
	logic [DVD_W-1:0]      quo;

	always_comb begin
		d     = signed'({1'b0, lsum_q}) - signed'({1'b0, lrng_q});
		rem_n = {rem_q, dvd_q[DVD_W-1]};
		qbit  = (rem_n >= {1'b0, ln_q});
		quo   = {dvd_q[DVD_W-2:0], qbit};
	end

	// finish
	logic t_now, c_now, te, ce, can_fin;
	always_comb begin
		t_now   = ci_q < trend_thr_q;
		c_now   = ci_q > chop_thr_q;
		te      = comp_q && t_now && !was_trend_q;
		ce      = comp_q && c_now && !was_chop_q;
		can_fin = !ovalid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			sel_q       <= SEL_SUM;
			win_q       <= WIN_RESET;
			min_q       <= MIN_RESET;
			trend_thr_q <= TREND_RESET;
			chop_thr_q  <= CHOP_RESET;
			wp_q        <= '0;
			fill_q      <= '0;
			n_q         <= '0;
			iss_q       <= '0;
			rcv_q       <= '0;
			raddr_q     <= '0;
			rvalid_q    <= 1'b0;
			comp_q      <= 1'b0;
			was_trend_q <= 1'b0;
			was_chop_q  <= 1'b0;
			tcnt_q      <= '0;
			ccnt_q      <= '0;
			scnt_q      <= '0;
			prev_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			sum_q       <= '0;
			e_q         <= '0;
			m_q         <= '0;
			frac_q      <= '0;
			k_q         <= '0;
			lsum_q      <= '0;
			lrng_q      <= '0;
			ln_q        <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			dc_q        <= '0;
			ci_q        <= CI_NEUTRAL;
			ovalid_q    <= 1'b0;
			choppiness  <= '0;
			trend_event <= 1'b0;
			chop_event  <= 1'b0;
			trend_count <= '0;
			chop_count  <= '0;
			sample_count <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_addr))
					REG_WINDOW: begin
						win_q  <= cfg_data[WIN_W-1:0];
						wp_q   <= '0;
						fill_q <= '0;
					end
					REG_MIN:   min_q       <= cfg_data[WIN_W-1:0];
					REG_TREND: trend_thr_q <= cfg_data;
					REG_CHOP:  chop_thr_q  <= cfg_data;
					default: ;
				endcase
			end

			// the finish step reloads the output register itself
			if (ovalid_q && out_ready && st_q != ST_FIN) begin
				ovalid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						wp_q     <= wp_new;
						fill_q   <= fill_new;
						n_q      <= fill_new;
						scnt_q   <= scnt_q + CNT_W'(1);
						raddr_q  <= start;
						iss_q    <= '0;
						rcv_q    <= '0;
						rvalid_q <= 1'b0;
						sum_q    <= '0;
						ci_q     <= CI_NEUTRAL;
						comp_q   <= (fill_new >= min_q);
						st_q     <= (fill_new >= min_q) ? ST_WALK : ST_FIN;
					end
				end
				ST_WALK: begin
					// one read issued per cycle, its data arrives in the next cycle
					rvalid_q <= (iss_q < n_q);
					if (iss_q < n_q) begin
						iss_q   <= iss_q + WIN_W'(1);
						raddr_q <= (raddr_inc == w) ? '0 : raddr_inc[ADDR_W-1:0];
					end
					if (rvalid_q) begin
						rcv_q  <= rcv_q + WIN_W'(1);
						prev_q <= cur;
						if (rcv_q == '0) begin
							lo_q <= cur;
							hi_q <= cur;
						end else begin
							sum_q <= sum_q + SUM_W'(adif);
							if (cur < lo_q) lo_q <= cur;
							if (cur > hi_q) hi_q <= cur;
						end
						if (rcv_q == n_q - WIN_W'(1)) begin
							st_q  <= ST_LNORM;
							sel_q <= SEL_SUM;
						end
					end
				end
				ST_LNORM: begin
					if (n_q < WIN_W'(2) || rng == '0 || sum_q == '0) begin
						ci_q <= CI_NEUTRAL;
						st_q <= ST_FIN;
					end else begin
						e_q    <= le;
						m_q    <= lm;
						frac_q <= '0;
						k_q    <= 4'd15;
						st_q   <= ST_LSQ;
					end
				end
				ST_LSQ: begin
					m_q    <= sq[31] ? sq[31:1] : sq[30:0];
					frac_q <= frac_new;
					k_q    <= k_q - 4'd1;
					if (k_q == '0) begin
						unique case (sel_q)
							SEL_SUM: begin
								lsum_q <= lres;
								sel_q  <= SEL_RNG;
								st_q   <= ST_LNORM;
							end
							SEL_RNG: begin
								lrng_q <= lres;
								sel_q  <= SEL_N;
								st_q   <= ST_LNORM;
							end
							SEL_N: begin
								ln_q <= LN_W'(lres);
								st_q <= ST_MUL;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL: begin
					if (d[LOG_W] || d == '0) begin
						ci_q <= '0;
						st_q <= ST_FIN;
					end else begin
						dvd_q <= DVD_W'(d[LOG_W-1:0]) * DVD_W'(CI_FULL)
							+ DVD_W'(ln_q >> 1);
						rem_q <= '0;
						dc_q  <= 6'(DVD_W - 1);
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? LN_W'(rem_n - {1'b0, ln_q}) : rem_n[LN_W-1:0];
					dvd_q <= quo;
					dc_q  <= dc_q - 6'd1;
					if (dc_q == '0) begin
						ci_q <= (quo > DVD_W'(CI_FULL)) ? CI_FULL : quo[CI_W-1:0];
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (can_fin) begin
						if (comp_q) begin
							was_trend_q <= t_now;
							was_chop_q  <= c_now;
						end
						if (te) tcnt_q <= tcnt_q + CNT_W'(1);
						if (ce) ccnt_q <= ccnt_q + CNT_W'(1);
						choppiness   <= ci_q;
						trend_event  <= te;
						chop_event   <= ce;
						trend_count  <= tcnt_q + CNT_W'(te);
						chop_count   <= ccnt_q + CNT_W'(ce);
						sample_count <= scnt_q;
						ovalid_q     <= 1'b1;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (iss_q <= n_q && rcv_q <= iss_q))
		else $error("window walk ran past the held samples");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (ln_q != '0))
		else $error("divide with zero log of sample count");

	a_ci_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (choppiness <= CI_FULL))
		else $error("index above full scale");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (fill_q >= WIN_W'(1) && fill_q <= w))
		else $error("fill level outside window after accept");

endmodule
`default_nettype wire
